/* hdl/ik_pkg.sv */
package ik_pkg;

    localparam int KEY_WIDTH     = 32;
    localparam int SLOT_W        = 10;
    localparam int COUNT_W       = 11;
    localparam int TABLE_DEPTH_D = 1024;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [SLOT_W-1:0]    slot;
        logic [KEY_WIDTH-1:0] key;
    } ik_req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] found_slot;
    } ik_rsp_t;

    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_HIGH,
        SEL_MID
    } ik_sel_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_MID,
        SRC_LOW,
        SRC_HIGH
    } ik_src_t;

    typedef struct packed {
        logic    load_wr;
        logic    capture;
        logic    init;
        logic    rd_en;
        ik_sel_t rd_sel;
        logic    lat_lo;
        logic    div_start;
        logic    div_step;
        logic    mid_set;
        logic    upd;
        logic    res_set;
        ik_src_t res_src;
        logic    out_load;
    } ik_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic in_range;
        logic div_done;
        logic m_eq;
        logic loop_exit;
        logic low_ok;
        logic high_ok;
        logic out_free;
    } ik_stat_t;

endpackage

/* hdl/ik_ram.sv */
module ik_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/ik_ctrl.sv */
module ik_ctrl
    import ik_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_op,
    output logic     in_stall,
    input  ik_stat_t stat,
    output ik_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD_LO,
        S_RD_HI,
        S_CHECK,
        S_DIV,
        S_MID,
        S_RD_MID,
        S_CMP,
        S_LOOP,
        S_FIN_LO,
        S_FIN_LO_CMP,
        S_FIN_HI,
        S_FIN_HI_CMP,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel  = SEL_LOW;
        cmd.res_src = SRC_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_START;
                    end
                end
            end
            S_START:
            begin
                if (stat.count_zero)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                cmd.lat_lo = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_HIGH;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.in_range)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_FIN_LO;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                cmd.mid_set = 1'b1;
                state_next  = S_RD_MID;
            end
            S_RD_MID:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_MID;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.m_eq)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_src = SRC_MID;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                state_next = stat.loop_exit ? S_FIN_LO : S_RD_LO;
            end
            S_FIN_LO:
            begin
                if (stat.low_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FIN_LO_CMP;
                end
                else
                begin
                    state_next = S_FIN_HI;
                end
            end
            S_FIN_LO_CMP:
            begin
                if (stat.m_eq)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_src = SRC_LOW;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_FIN_HI;
                end
            end
            S_FIN_HI:
            begin
                if (stat.high_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_HIGH;
                    state_next = S_FIN_HI_CMP;
                end
                else
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_RESULT;
                end
            end
            S_FIN_HI_CMP:
            begin
                cmd.res_set = 1'b1;
                cmd.res_src = stat.m_eq ? SRC_HIGH : SRC_NONE;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/ik_dpath.sv */
module ik_dpath
    import ik_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_D
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ik_req_t            in_req,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               out_stall,
    output logic               out_valid,
    output ik_rsp_t            out_rsp,
    input  ik_cmd_t            cmd,
    output ik_stat_t           stat
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int XW = IW + 1;
    localparam int BW = $clog2(IW + 1);

    localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);

    logic [COUNT_W-1:0]   entry_count_reg;
    logic                 out_valid_reg;
    ik_rsp_t              out_rsp_reg;

    logic [KEY_WIDTH-1:0] want_reg;
    logic [KEY_WIDTH-1:0] lo_key_reg;
    logic [XW-1:0]        low_reg;
    logic [XW-1:0]        high_reg;
    logic [XW-1:0]        mid_reg;

    logic [KEY_WIDTH-1:0] den_reg;
    logic [KEY_WIDTH-1:0] num_reg;
    logic [KEY_WIDTH-1:0] r_reg;
    logic [KEY_WIDTH-1:0] r_next;
    logic [IW-1:0]        q_reg;
    logic [IW-1:0]        q_next;
    logic [IW-1:0]        mul_reg;
    logic [BW-1:0]        bits_reg;
    logic                 phase_reg;

    logic                 res_found_reg;
    logic [SLOT_W-1:0]    res_slot_reg;

    logic [XW-1:0]        sat_count;
    logic [XW-1:0]        mid_sum;
    logic [KEY_WIDTH-1:0] dbl_gap;
    logic [KEY_WIDTH-1:0] add_gap;
    logic [KEY_WIDTH-1:0] rdata;
    logic [IW-1:0]        raddr;
    logic                 ram_we;
    logic                 m_lt;

    assign ram_we = cmd.load_wr && (32'(in_req.slot) < 32'(TABLE_DEPTH));

    always_comb
    begin
        case (cmd.rd_sel)
            SEL_LOW:  raddr = IW'(low_reg);
            SEL_HIGH: raddr = IW'(high_reg);
            SEL_MID:  raddr = IW'(mid_reg);
            default:  raddr = IW'(low_reg);
        endcase
    end

    ik_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IW'(in_req.slot)),
        .wdata (in_req.key),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sat_count = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? DEPTH_X
                                                                 : XW'(entry_count_reg);
    assign mid_sum   = low_reg + XW'(q_reg);
    assign m_lt      = (rdata < want_reg);

    assign stat.count_zero = (entry_count_reg == '0);
    assign stat.in_range   = (lo_key_reg < want_reg) && (rdata > want_reg);
    assign stat.div_done   = phase_reg && (bits_reg == BW'(1));
    assign stat.m_eq       = (rdata == want_reg);
    assign stat.loop_exit  = (low_reg > high_reg) || (high_reg >= DEPTH_X);
    assign stat.low_ok     = (low_reg < DEPTH_X);
    assign stat.high_ok    = (high_reg < DEPTH_X);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // one doubling half-step, then one conditional add of the numerator
    always_comb
    begin
        dbl_gap = den_reg - r_reg;
        add_gap = den_reg - num_reg;
        r_next  = r_reg;
        q_next  = q_reg;
        if (!phase_reg)
        begin
            if (r_reg >= dbl_gap)
            begin
                r_next = r_reg - dbl_gap;
                q_next = IW'({q_reg, 1'b1});
            end
            else
            begin
                r_next = r_reg + r_reg;
                q_next = IW'({q_reg, 1'b0});
            end
        end
        else if (mul_reg[IW-1])
        begin
            if (r_reg >= add_gap)
            begin
                r_next = r_reg - add_gap;
                q_next = q_reg + IW'(1);
            end
            else
            begin
                r_next = r_reg + num_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= COUNT_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                entry_count_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            want_reg <= in_req.key;
        end
        if (cmd.init)
        begin
            low_reg  <= '0;
            high_reg <= sat_count - XW'(1);
        end
        if (cmd.lat_lo)
        begin
            lo_key_reg <= rdata;
        end
        if (cmd.div_start)
        begin
            den_reg   <= rdata - lo_key_reg;
            num_reg   <= want_reg - lo_key_reg;
            mul_reg   <= IW'(high_reg - low_reg);
            r_reg     <= '0;
            q_reg     <= '0;
            bits_reg  <= BW'(IW);
            phase_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            r_reg     <= r_next;
            q_reg     <= q_next;
            phase_reg <= !phase_reg;
            if (phase_reg)
            begin
                mul_reg  <= IW'({mul_reg, 1'b0});
                bits_reg <= bits_reg - BW'(1);
            end
        end
        if (cmd.mid_set)
        begin
            mid_reg <= (mid_sum > high_reg) ? high_reg : mid_sum;
        end
        if (cmd.upd)
        begin
            if (m_lt)
            begin
                low_reg <= mid_reg + XW'(1);
            end
            else
            begin
                high_reg <= mid_reg - XW'(1);
            end
        end
        if (cmd.res_set)
        begin
            case (cmd.res_src)
                SRC_MID:
                begin
                    res_found_reg <= 1'b1;
                    res_slot_reg  <= SLOT_W'(mid_reg);
                end
                SRC_LOW:
                begin
                    res_found_reg <= 1'b1;
                    res_slot_reg  <= SLOT_W'(low_reg);
                end
                SRC_HIGH:
                begin
                    res_found_reg <= 1'b1;
                    res_slot_reg  <= SLOT_W'(high_reg);
                end
                default:
                begin
                    res_found_reg <= 1'b0;
                    res_slot_reg  <= '0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_rsp_reg.found      <= res_found_reg;
            out_rsp_reg.found_slot <= res_slot_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

endmodule

/* hdl/interpolation_key_search_core.sv */
// interpolation key search over an ascending key table held in one ram
// in channel: in_valid / in_stall carrying in_req (op, slot, key)
//   op load writes key into slot and gives no response; slots beyond the
//   table are dropped. op search looks the key up over slots 0 .. count-1
// out channel: out_valid / out_stall carrying out_rsp (found, found_slot),
//   exactly one response per search request, found_slot is 0 on a miss
// cfg_write / cfg_data set the slot count; it should only change when idle
// one request is handled at a time; in_stall is high while a search runs
// a load is written from idle and leaves the block idle; a search runs set-up,
//   then per probe two ram reads of the end keys, a radix-2 scaled divide
//   with a doubling step and a conditional add step per index bit, and one
//   ram read of the probe, then the end checks; the registered ram read sets
//   the read steps
// the response sits in an output register; further requests are still taken
//   while it waits, and a finished search holds until the register frees
// out_stall holds the response steady
// reset clears the control state and sets the count to 1024; the table
//   contents are undefined until loaded
module interpolation_key_search_core
    import ik_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_D
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ik_req_t            in_req,
    output logic               out_valid,
    input  logic               out_stall,
    output ik_rsp_t            out_rsp,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data
);

    ik_cmd_t  cmd;
    ik_stat_t stat;

    ik_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_req.op),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ik_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (in_req),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_rsp   (out_rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

    // a response only enters a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("response loaded over a pending one");

    // out_valid only rises from a finished search
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("response without a search");

    // a load leaves the block ready for the next request
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_wr |=> !in_stall)
        else $error("load did not return to idle");

    // a probe update never happens on a hit
    a_upd_miss: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> !stat.m_eq)
        else $error("bounds moved on a hit");

endmodule
